// ===== rtl/polynomial_bisection_root_assert.svh =====
// Assertion macros for the polynomial bisection root finder.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH
`define POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH
`ifndef SYNTHESIS
`define PBR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: check failed");
`define PBR_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define PBR_ASSERT(lbl, clk, rstn, prop)
`define PBR_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/pbr_pkg.sv =====
// Shared constants for the polynomial bisection root finder.
// No dependencies; used by polynomial_bisection_root.
`timescale 1ns / 1ps

package pbr_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned TOL_W   = 31;
	localparam int unsigned DEG_W   = 4;
	localparam int unsigned FRAC_W  = 16;

	localparam int unsigned S_TDATA_W = 136;
	localparam int unsigned M_TDATA_W = 32;
	localparam int unsigned M_TUSER_W = 2;

	// input word layout
	localparam int unsigned IDX_LSB   = 0;
	localparam int unsigned COEF_LSB  = 4;
	localparam int unsigned LEFT_LSB  = 36;
	localparam int unsigned RIGHT_LSB = 68;
	localparam int unsigned TOL_LSB   = 100;

	// output flag bits in tuser
	localparam int unsigned FLAG_EXACT = 0;
	localparam int unsigned FLAG_CAP   = 1;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_SOLVE = 1'b1
	} func_t;

endpackage

// ===== rtl/polynomial_bisection_root.sv =====
// Polynomial root finder by interval bisection, Horner evaluation on one multiplier.
// Depends on pbr_pkg and polynomial_bisection_root_assert.svh.
//
//  channel  | dir | signals                       | content
//  ---------+-----+-------------------------------+-----------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata/user| load coefficient or solve request
//  m_*      | out | m_tvalid m_tready m_tdata/user| root and stop flags, one per solve
//  cfg_*    | in  | cfg_we cfg_wdata              | polynomial degree
//
// A load word is written into the coefficient store as it is taken. A solve word runs one
// Horner pass at the left end, then up to MAX_STEPS halvings, each a Horner pass at the
// midpoint on the single 32x32 multiplier, every coefficient passing a multiply state, then an add state.
// s_tready is low from acceptance of a solve word until its result is registered.
// A finished result waits in the output register while the next word is taken.
// Reset clears the coefficient store, the degree and all control state at once.
`timescale 1ns / 1ps
`include "polynomial_bisection_root_assert.svh"

module polynomial_bisection_root #(
	parameter int MAX_DEGREE = 15,
	parameter int MAX_STEPS  = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// coef_index, coef_value, left_end, right_end, tolerance, zero pad
	input  logic [pbr_pkg::S_TDATA_W-1:0]  s_tdata,
	// func
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// root
	output logic [pbr_pkg::M_TDATA_W-1:0]  m_tdata,
	// exact_hit, step_limit_hit
	output logic [pbr_pkg::M_TUSER_W-1:0]  m_tuser,
	input  logic                           cfg_we,
	input  logic [pbr_pkg::DEG_W-1:0]      cfg_wdata
);

	localparam int DEPTH = (MAX_DEGREE + 1 < 16) ? MAX_DEGREE + 1 : 16;
	localparam int CW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_STEPS + 1);
	localparam int DW    = pbr_pkg::DATA_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_ADD,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic signed [DW-1:0]   coef_q [DEPTH];
	logic [pbr_pkg::DEG_W-1:0] degree_q;
	logic [CW-1:0]          n_q;
	logic [CW-1:0]          idx_q;
	logic [SW-1:0]          steps_q;
	logic signed [DW-1:0]   left_q, right_q, x_q, acc_q, fl_q;
	logic [pbr_pkg::TOL_W-1:0] tol_q;
	logic                   fl_valid_q;
	logic                   eval_mid_q;
	logic                   exact_q, cap_q;
	logic signed [2*DW-1:0] prod_s1;

	logic                   s_take;
	logic [pbr_pkg::IDX_W-1:0] in_idx;
	logic [pbr_pkg::TOL_W-1:0] in_tol;
	logic [CW-1:0]          n_eff;
	logic signed [DW:0]     mid_sum;
	logic signed [DW-1:0]   mid;
	logic signed [DW:0]     width;
	logic                   narrow;
	logic signed [DW-1:0]   scaled;
	logic signed [DW:0]     add_sum;
	logic signed [DW-1:0]   acc_next;
	logic                   keep_left;

	assign s_tready = (state_q == ST_IDLE);
	assign s_take   = s_tvalid && s_tready;
	assign in_idx   = s_tdata[pbr_pkg::IDX_LSB +: pbr_pkg::IDX_W];
	assign in_tol   = s_tdata[pbr_pkg::TOL_LSB +: pbr_pkg::TOL_W];

	always_comb begin
		if (32'(degree_q) > 32'(MAX_DEGREE)) begin
			n_eff = CW'(MAX_DEGREE);
		end else begin
			n_eff = degree_q[CW-1:0];
		end
	end

	// midpoint floor((l+r)/2) and width r-l, both exact in 33 bits
	assign mid_sum = {left_q[DW-1], left_q} + {right_q[DW-1], right_q};
	assign mid     = mid_sum[DW:1];
	assign width   = {right_q[DW-1], right_q} - {left_q[DW-1], left_q};
	assign narrow  = width < $signed({2'b00, tol_q});

	// Horner step: saturate floor(acc*x/2^16), add coefficient, saturate again
	always_comb begin
		if (prod_s1[2*DW-1:DW+pbr_pkg::FRAC_W-1] != {(DW-pbr_pkg::FRAC_W+1){1'b0}} &&
		    prod_s1[2*DW-1:DW+pbr_pkg::FRAC_W-1] != {(DW-pbr_pkg::FRAC_W+1){1'b1}}) begin
			scaled = prod_s1[2*DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			scaled = prod_s1[DW+pbr_pkg::FRAC_W-1:pbr_pkg::FRAC_W];
		end
		add_sum = {scaled[DW-1], scaled} + {coef_q[idx_q][DW-1], coef_q[idx_q]};
		if (add_sum[DW] != add_sum[DW-1]) begin
			acc_next = add_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			acc_next = add_sum[DW-1:0];
		end
	end

	assign keep_left = (fl_q < 0 && acc_q > 0) || (fl_q > 0 && acc_q < 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (cfg_we) begin
			degree_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				coef_q[i] <= '0;
			end
		end else if (s_take && s_tuser == pbr_pkg::FUNC_LOAD &&
		             32'(in_idx) <= 32'(MAX_DEGREE)) begin
			coef_q[in_idx[CW-1:0]] <= s_tdata[pbr_pkg::COEF_LSB +: DW];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= acc_q * x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= '0;
			steps_q    <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			fl_valid_q <= 1'b0;
			eval_mid_q <= 1'b0;
			exact_q    <= 1'b0;
			cap_q      <= 1'b0;
			left_q     <= '0;
			right_q    <= '0;
			tol_q      <= '0;
			x_q        <= '0;
			acc_q      <= '0;
			fl_q       <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_FINISH) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_take && s_tuser == pbr_pkg::FUNC_SOLVE) begin
						left_q     <= s_tdata[pbr_pkg::LEFT_LSB +: DW];
						right_q    <= s_tdata[pbr_pkg::RIGHT_LSB +: DW];
						tol_q      <= (in_tol == '0) ? pbr_pkg::TOL_W'(1) : in_tol;
						n_q        <= n_eff;
						steps_q    <= '0;
						fl_valid_q <= 1'b0;
						exact_q    <= 1'b0;
						cap_q      <= 1'b0;
						state_q    <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					idx_q <= '0;
					acc_q <= '0;
					if (narrow) begin
						x_q     <= mid;
						state_q <= ST_FINISH;
					end else if (steps_q == SW'(MAX_STEPS)) begin
						x_q     <= mid;
						cap_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (!fl_valid_q) begin
						x_q        <= left_q;
						eval_mid_q <= 1'b0;
						state_q    <= ST_MUL;
					end else begin
						x_q        <= mid;
						eval_mid_q <= 1'b1;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q <= acc_next;
					if (idx_q == n_q) begin
						state_q <= ST_DECIDE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DECIDE: begin
					if (!eval_mid_q) begin
						fl_q       <= acc_q;
						fl_valid_q <= 1'b1;
						state_q    <= ST_CHECK;
					end else if (acc_q == '0) begin
						exact_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						if (keep_left) begin
							right_q <= x_q;
						end else begin
							left_q <= x_q;
							fl_q   <= acc_q;
						end
						steps_q <= steps_q + SW'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid                    <= 1'b1;
						m_tdata                     <= x_q;
						m_tuser[pbr_pkg::FLAG_EXACT] <= exact_q;
						m_tuser[pbr_pkg::FLAG_CAP]   <= cap_q;
						state_q                     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PBR_ASSERT_NEVER(a_flags_exclusive, clk, arst_n, m_tvalid && m_tuser[0] && m_tuser[1])
	`PBR_ASSERT_NEVER(a_steps_in_range, clk, arst_n, 32'(steps_q) > 32'(MAX_STEPS))
	`PBR_ASSERT(a_idx_in_range, clk, arst_n, (state_q == ST_MUL || state_q == ST_ADD) |-> idx_q <= n_q)
	`PBR_ASSERT(a_interval_ordered, clk, arst_n, (state_q == ST_MUL) |-> left_q <= right_q)

endmodule

// ===== dv/tb_polynomial_bisection_root.sv =====
// Testbench for polynomial_bisection_root: loads coefficients, sets the degree and
// solves on intervals, checking each root word against a fixed-point bisection predictor.
// Depends on pbr_pkg and the polynomial_bisection_root RTL.
`timescale 1ns / 1ps

module tb_polynomial_bisection_root;

	localparam int MAX_DEGREE   = 15;
	localparam int MAX_STEPS    = 40;
	localparam int IDLE_LIMIT   = 10000;
	localparam int RANDOM_WORDS = 850;

	typedef struct {
		pbr_pkg::func_t func;
		logic [3:0]  slot;
		logic [31:0] coef;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [30:0] tol;
	} poly_word_t;

	typedef struct {
		logic [31:0] root;
		logic        exact;
		logic        capped;
	} root_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [pbr_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                          s_tuser   = pbr_pkg::FUNC_LOAD;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [pbr_pkg::M_TDATA_W-1:0] m_tdata;
	logic [pbr_pkg::M_TUSER_W-1:0] m_tuser;
	logic                          cfg_we    = 1'b0;
	logic [pbr_pkg::DEG_W-1:0]     cfg_wdata = '0;

	poly_word_t   pending[$];
	root_result_t roots_due[$];
	int           coef_model[MAX_DEGREE+1];
	logic [3:0]   deg_model;

	poly_word_t                    cur_word;
	logic [pbr_pkg::S_TDATA_W-1:0] bus;
	root_result_t                  want;
	int unsigned                   gap_cnt;
	int unsigned                   stall_cnt;
	int unsigned                   idle_cycles;
	bit                            drive_calm;
	bit                            sink_calm;

	int errors;
	int n_queued;
	int n_loads;
	int n_solves;
	int n_results;
	int n_exact;
	int n_capped;
	int n_settings;

	polynomial_bisection_root #(
		.MAX_DEGREE(MAX_DEGREE),
		.MAX_STEPS (MAX_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int poly_at(int x);
		int     acc;
		longint p;
		int     i;
		acc = 0;
		for (i = 0; i <= int'(deg_model); i++) begin
			p = (longint'(acc) * longint'(x)) >>> 16;
			acc = clamp32(p);
			acc = clamp32(longint'(acc) + longint'(coef_model[i]));
		end
		return acc;
	endfunction

	function automatic root_result_t bisect_root(int lo_in, int hi_in, logic [30:0] tol_in);
		longint       lo, hi, mid, span, tol;
		int           fm, fl, steps;
		root_result_t r;
		lo = longint'(lo_in);
		hi = longint'(hi_in);
		tol = longint'(tol_in);
		if (tol == 0)
			tol = 1;
		r.exact = 1'b0;
		r.capped = 1'b0;
		steps = 0;
		mid = (lo + hi) >>> 1;
		span = hi - lo;
		while (span >= tol) begin
			if (steps >= MAX_STEPS) begin
				r.capped = 1'b1;
				break;
			end
			fm = poly_at(int'(mid));
			if (fm == 0) begin
				r.exact = 1'b1;
				break;
			end
			fl = poly_at(int'(lo));
			if ((fl < 0 && fm > 0) || (fl > 0 && fm < 0))
				hi = mid;
			else
				lo = mid;
			mid = (lo + hi) >>> 1;
			span = hi - lo;
			steps++;
		end
		r.root = mid[31:0];
		return r;
	endfunction

	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// signed Q16.16 in [-m, m], half of them whole numbers
	function automatic int small_q(int m);
		if ($urandom_range(0, 1))
			return (int'($urandom_range(0, 2 * m)) - m) <<< 16;
		return int'($urandom_range(0, (2 * m) << 16)) - (m <<< 16);
	endfunction

	function automatic poly_word_t rand_word();
		poly_word_t w;
		w.func = pbr_pkg::func_t'($urandom_range(0, 1));
		w.slot = 4'($urandom);
		w.coef = $urandom;
		w.lo   = $urandom;
		w.hi   = $urandom;
		w.tol  = 31'($urandom);
		return w;
	endfunction

	function automatic logic [30:0] rand_tol();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 31'd1;
		if (r < 6)
			return 31'($urandom_range(2, 'hFFFF));
		if (r < 9)
			return 31'($urandom_range(1 << 16, 1 << 20));
		return 31'($urandom);
	endfunction

	task automatic queue_load(int slot, int value);
		poly_word_t w;
		w = rand_word();
		w.func = pbr_pkg::FUNC_LOAD;
		w.slot = 4'(slot);
		w.coef = value;
		pending.push_back(w);
		n_queued++;
	endtask

	task automatic queue_solve(int lo, int hi, logic [30:0] tol);
		poly_word_t w;
		w = rand_word();
		w.func = pbr_pkg::FUNC_SOLVE;
		w.lo = lo;
		w.hi = hi;
		w.tol = tol;
		pending.push_back(w);
		n_queued++;
	endtask

	task automatic set_degree(int d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= pbr_pkg::DEG_W'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		deg_model = 4'(d);
		n_settings++;
	endtask

	// hold until every queued word is taken and every root has come back
	task automatic settle();
		while (n_loads + n_solves != n_queued || roots_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(string what);
		errors++;
		$display("[%0t] result %0d: %s", $time, n_results, what);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_cnt <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (cur_word.func == pbr_pkg::FUNC_LOAD) begin
					coef_model[cur_word.slot] = cur_word.coef;
					n_loads++;
				end else begin
					roots_due.push_back(bisect_root(cur_word.lo, cur_word.hi, cur_word.tol));
					n_solves++;
				end
			end
			if (s_tvalid && !s_tready) begin
				// hold the word
			end else if (gap_cnt != 0) begin
				s_tvalid <= 1'b0;
				gap_cnt <= gap_cnt - 1;
			end else if (pending.size() != 0) begin
				cur_word = pending.pop_front();
				bus = '0;
				bus[pbr_pkg::IDX_LSB +: pbr_pkg::IDX_W] = cur_word.slot;
				bus[pbr_pkg::COEF_LSB +: pbr_pkg::DATA_W] = cur_word.coef;
				bus[pbr_pkg::LEFT_LSB +: pbr_pkg::DATA_W] = cur_word.lo;
				bus[pbr_pkg::RIGHT_LSB +: pbr_pkg::DATA_W] = cur_word.hi;
				bus[pbr_pkg::TOL_LSB +: pbr_pkg::TOL_W] = cur_word.tol;
				s_tdata <= bus;
				s_tuser <= cur_word.func;
				s_tvalid <= 1'b1;
				gap_cnt <= drive_calm ? 0 : pick_pause();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (roots_due.size() == 0) begin
					report_mismatch("root word with no solve outstanding");
				end else begin
					want = roots_due.pop_front();
					if (m_tdata !== want.root)
						report_mismatch($sformatf("root %h, predicted %h", m_tdata, want.root));
					if (m_tuser[pbr_pkg::FLAG_EXACT] !== want.exact)
						report_mismatch($sformatf("exact_hit %b, predicted %b",
							m_tuser[pbr_pkg::FLAG_EXACT], want.exact));
					if (m_tuser[pbr_pkg::FLAG_CAP] !== want.capped)
						report_mismatch($sformatf("step_limit_hit %b, predicted %b",
							m_tuser[pbr_pkg::FLAG_CAP], want.capped));
					n_exact += int'(want.exact);
					n_capped += int'(want.capped);
				end
			end
			if (stall_cnt != 0) begin
				m_tready <= 1'b0;
				stall_cnt <= stall_cnt - 1;
			end else begin
				m_tready <= 1'b1;
				if (!sink_calm && $urandom_range(0, 99) < 20)
					stall_cnt <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no word moved for %0d cycles", IDLE_LIMIT);
				$display("polynomial_bisection_root: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int base;
		int d;
		int k;
		int lo;
		int hi;
		int tmp;
		int unsigned r;

		foreach (coef_model[i])
			coef_model[i] = 0;
		deg_model = '0;
		drive_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty store: zero everywhere, so the first midpoint hits
		set_degree(0);
		queue_solve(-32'sh10000, 32'sh30000, 31'd0);
		queue_load(0, 32'h7FFFFFFF);
		queue_load(15, 32'h80000000);
		// constant positive over the widest interval runs into the step cap
		queue_solve(32'h80000000, 32'h7FFFFFFF, 31'd0);
		queue_solve(32'sh50000, -32'sh50000, 31'd1);
		queue_solve(32'sh10000, 32'sh18000, 31'h7FFFFFFF);
		settle();

		// x - 2: exact zero at the first midpoint of [0, 4]
		set_degree(1);
		queue_load(0, 32'sh10000);
		queue_load(1, -32'sh20000);
		queue_solve(0, 32'sh40000, 31'd0);
		queue_solve(0, 32'sh30000, 31'h100);
		queue_solve(-32'sh30000, 32'sh8000, 31'h7FFFFFFF);
		settle();

		set_degree(15);
		queue_load(7, 32'sh18000);
		queue_solve(32'h80000000, 32'h7FFFFFFF, 31'd0);
		queue_solve(-32'sh20000, 32'sh20000, 31'h10);
		queue_solve(32'sh7FFF0000, 32'sh7FFFFFFF, 31'd1);
		settle();

		base = n_queued;
		while (n_queued - base < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				d = $urandom_range(0, 1);
			else if (r < 75)
				d = $urandom_range(2, 4);
			else if (r < 92)
				d = $urandom_range(5, 9);
			else
				d = $urandom_range(10, 15);
			drive_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			set_degree(d);
			if ($urandom_range(0, 4) != 0) begin
				for (k = 0; k <= d; k++)
					queue_load(k, ($urandom_range(0, 3) != 0) ? small_q(4) : int'($urandom));
				repeat ($urandom_range(2, 8)) begin
					lo = small_q(16);
					hi = lo + int'($urandom_range(0, 32 << 16));
					r = $urandom_range(0, 19);
					if (r == 0) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end else if (r == 1) begin
						lo = $urandom;
						hi = $urandom;
					end else if (r == 2) begin
						hi = lo;
					end
					if ($urandom_range(0, 9) == 0) begin
						pending.push_back(rand_word());
						n_queued++;
					end
					queue_solve(lo, hi, rand_tol());
				end
			end else begin
				repeat ($urandom_range(3, 12)) begin
					pending.push_back(rand_word());
					n_queued++;
				end
			end
			settle();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d loads and %0d solves over %0d degree settings",
			n_loads, n_solves, n_settings);
		$display("%0d roots checked: %0d exact zeros, %0d stopped at the step cap",
			n_results, n_exact, n_capped);
		if (errors == 0)
			$display("polynomial_bisection_root: match");
		else
			$display("polynomial_bisection_root: mismatch");
		$finish;
	end

endmodule
